### src/sav_pkg.sv
// ----------------------------------------------------------------------------
// sav_pkg
// shared types, constants and the key order map for the stable argsort vector
// ----------------------------------------------------------------------------
`default_nettype none

package sav_pkg;

    localparam int KEY_W       = 64;
    localparam int POS_W       = 7;
    localparam int MAX_LEN_DEF = 64;

    typedef struct packed {
        logic [KEY_W-1:0] key_bits;
        logic             last_in;
    } sav_in_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             last_out;
        logic             overflow;
    } sav_out_t;

    // control broadcast to every cell
    typedef struct packed {
        logic insert;
        logic drain;
        logic desc;
    } sav_ctl_t;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } sav_state_t;

    // total-order code, -0 folded onto +0
    function automatic logic [KEY_W-1:0] order_code(input logic [KEY_W-1:0] bits);
        logic [KEY_W-1:0] b;
        b = bits;
        if (b == {1'b1, {(KEY_W-1){1'b0}}})
        begin
            b = '0;
        end
        if (b[KEY_W-1])
        begin
            return ~b;
        end
        return b | {1'b1, {(KEY_W-1){1'b0}}};
    endfunction

endpackage

`default_nettype wire

### src/sav_cell.sv
// ----------------------------------------------------------------------------
// sav_cell
// one slot of the insertion chain: holds a code and its arrival position
// ----------------------------------------------------------------------------
`default_nettype none

module sav_cell (
    input  wire logic                     clk,
    input  wire sav_pkg::sav_ctl_t        ctl,
    input  wire logic                     occupied,
    input  wire logic [sav_pkg::KEY_W-1:0] new_code,
    input  wire logic [sav_pkg::POS_W-1:0] new_pos,
    input  wire logic                     found_in,
    input  wire logic [sav_pkg::KEY_W-1:0] prev_code,
    input  wire logic [sav_pkg::POS_W-1:0] prev_pos,
    input  wire logic [sav_pkg::KEY_W-1:0] next_code,
    input  wire logic [sav_pkg::POS_W-1:0] next_pos,
    output logic                          found_out,
    output logic [sav_pkg::KEY_W-1:0]     code,
    output logic [sav_pkg::POS_W-1:0]     pos
);
    import sav_pkg::*;

    logic [KEY_W-1:0] code_reg, code_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             here;

    // new key goes before this slot, or the slot is empty
    assign here      = !occupied || (ctl.desc ? (new_code > code_reg) : (new_code < code_reg));
    assign found_out = found_in || here;

    always_comb
    begin
        code_next = code_reg;
        pos_next  = pos_reg;
        priority if (ctl.drain)
        begin
            code_next = next_code;
            pos_next  = next_pos;
        end
        else if (ctl.insert && found_in)
        begin
            code_next = prev_code;
            pos_next  = prev_pos;
        end
        else if (ctl.insert && here)
        begin
            code_next = new_code;
            pos_next  = new_pos;
        end
        else
        begin
            code_next = code_reg;
            pos_next  = pos_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        pos_reg  <= pos_next;
    end

    assign code = code_reg;
    assign pos  = pos_reg;

endmodule

`default_nettype wire

### src/stable_argsort_vector.sv
// ----------------------------------------------------------------------------
// stable_argsort_vector
// stable argsort of one vector of double keys through an insertion chain
// ----------------------------------------------------------------------------
//  channel | handshake          | word
//  in      | in_valid/in_stall  | in_word  (key_bits, last_in)
//  out     | out_valid/out_stall| out_word (position, last_out, overflow)
//  cfg     | cfg_valid/cfg_ready| cfg_data (descending_order)
//
// keys enter one per cycle while loading; each goes into the cell row in that
// cycle by a compare in every cell and a found chain through the row.
// keys past a full row are dropped and flag overflow. after the last key the
// row shifts toward cell 0, one position per cycle unless out_stall holds it;
// input stalls meanwhile. out_stall holds the output register and the drain.
// reset empties the row through the fill count; cell contents are not cleared.
`default_nettype none

module stable_argsort_vector #(
    parameter int MAX_LEN = sav_pkg::MAX_LEN_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire sav_pkg::sav_in_t  in_word,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output sav_pkg::sav_out_t      out_word,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_data
);
    import sav_pkg::*;

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    sav_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             desc_reg;
    logic             out_valid_reg, out_valid_next;
    sav_out_t         out_reg, out_next;

    logic             in_acc, full, take_out;
    sav_ctl_t         ctl;
    logic [KEY_W-1:0] new_code;
    logic [POS_W-1:0] new_pos;

    logic [KEY_W-1:0] codes [MAX_LEN];
    logic [POS_W-1:0] poss  [MAX_LEN];
    logic             found [MAX_LEN+1];

    assign in_acc   = in_valid && !in_stall;
    assign full     = (count_reg == CNT_W'(MAX_LEN));
    assign take_out = (state_reg == ST_DRAIN) && (!out_valid_reg || !out_stall);
    assign new_code = order_code(in_word.key_bits);
    assign new_pos  = POS_W'(count_reg + CNT_W'(1));

    assign ctl = '{insert: in_acc && !full, drain: take_out, desc: desc_reg};

    assign found[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < MAX_LEN; g++)
        begin : g_cell
            logic [KEY_W-1:0] pc, nc;
            logic [POS_W-1:0] pp, np;
            if (g == 0)
            begin : g_first
                assign pc = new_code;
                assign pp = new_pos;
            end
            else
            begin : g_mid
                assign pc = codes[g-1];
                assign pp = poss[g-1];
            end
            if (g == MAX_LEN - 1)
            begin : g_end
                assign nc = codes[g];
                assign np = poss[g];
            end
            else
            begin : g_inner
                assign nc = codes[g+1];
                assign np = poss[g+1];
            end
            sav_cell u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .occupied  (CNT_W'(g) < count_reg),
                .new_code  (new_code),
                .new_pos   (new_pos),
                .found_in  (found[g]),
                .prev_code (pc),
                .prev_pos  (pp),
                .next_code (nc),
                .next_pos  (np),
                .found_out (found[g+1]),
                .code      (codes[g]),
                .pos       (poss[g])
            );
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc && in_word.last_in)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (take_out && count_reg == CNT_W'(1))
                begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // outputs and counters
    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        in_stall       = 1'b1;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_stall = 1'b0;
                if (in_acc)
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                if (take_out)
                begin
                    out_next.position = poss[0];
                    out_next.last_out = (count_reg == CNT_W'(1));
                    out_next.overflow = ovf_reg;
                    out_valid_next    = 1'b1;
                    count_next        = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        ovf_next = 1'b0;
                    end
                end
            end
            default: in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            desc_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                desc_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

`default_nettype wire

### dv/stable_argsort_vector_tb.sv
// ----------------------------------------------------------------------------
// stable_argsort_vector_tb
// streams key vectors into the argsort block and checks every emitted position
// against an insertion-sort predictor, under random idling on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class argsort_board;
    logic [63:0]     keys[$];
    logic [6:0]      slots[$];
    bit              ovf;
    bit              desc;
    sav_pkg::sav_out_t pending[$];
    int              errors;

    function new();
        errors = 0;
        ovf = 0;
        desc = 0;
    endfunction

    function logic [63:0] map_key(logic [63:0] b);
        if (b == 64'h8000_0000_0000_0000)
            b = '0;
        if (b[63])
            return ~b;
        return b | 64'h8000_0000_0000_0000;
    endfunction

    function void note_input(sav_pkg::sav_in_t w);
        int at;
        logic [63:0] c;
        sav_pkg::sav_out_t r;
        if (keys.size() < 64)
        begin
            c = map_key(w.key_bits);
            at = 0;
            while (at < keys.size())
            begin
                if (desc ? (c > keys[at]) : (c < keys[at]))
                    break;
                at++;
            end
            slots.insert(at, 7'(keys.size() + 1));
            keys.insert(at, c);
        end
        else
            ovf = 1;
        if (w.last_in)
        begin
            foreach (slots[k])
            begin
                r.position = slots[k];
                r.last_out = (k == slots.size() - 1);
                r.overflow = ovf;
                pending.push_back(r);
            end
            keys.delete();
            slots.delete();
            ovf = 0;
        end
    endfunction

    function void check_result(sav_pkg::sav_out_t got);
        sav_pkg::sav_out_t exp;
        if (pending.size() == 0)
        begin
            $display("%0t unexpected word: expected none, actual %h", $time, got);
            errors++;
            return;
        end
        exp = pending.pop_front();
        if (got !== exp)
        begin
            $display("%0t mismatch: expected pos %0d last %b ovf %b, actual pos %0d last %b ovf %b",
                     $time, exp.position, exp.last_out, exp.overflow,
                     got.position, got.last_out, got.overflow);
            errors++;
        end
    endfunction
endclass

module stable_argsort_vector_tb;
    import sav_pkg::*;

    logic     clk = 0;
    logic     rst_n = 0;
    logic     in_valid = 0;
    logic     in_stall;
    sav_in_t  in_word = '0;
    logic     out_valid;
    logic     out_stall = 0;
    sav_out_t out_word;
    logic     cfg_valid = 0;
    logic     cfg_ready;
    logic     cfg_data = 0;

    int  send_idle = 0;
    int  recv_idle = 0;
    int  hold_cycles = 0;
    int  cycles = 0;
    argsort_board board = new();

    stable_argsort_vector u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (rst_n && out_valid && !out_stall)
            board.check_result(out_word);
        if (cycles > 400000)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver stall, with an optional long hold-off
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle);
    end

    // valid stays high into the next word; idling and drain_all drop it
    task automatic send_word(logic [63:0] k, logic lst);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_word <= '{key_bits: k, last_in: lst};
        in_valid <= 1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_input('{key_bits: k, last_in: lst});
        @(negedge clk);
    endtask

    task automatic drain_all();
        in_valid <= 0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic write_order(logic d);
        drain_all();
        cfg_data <= d;
        cfg_valid <= 1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.desc = d;
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    function automatic logic [63:0] rand_key();
        logic [63:0] k;
        k = {$urandom, $urandom};
        case ($urandom_range(5))
            0: k = 64'h8000_0000_0000_0000;
            1: k = 64'h0;
            2: k = {k[63], 11'h3ff, 50'h0, k[1:0]};
            3: k = {k[63], 11'h7fe, k[51:0]};
            default: ;
        endcase
        return k;
    endfunction

    task automatic send_vector(int n);
        for (int i = 0; i < n; i++)
            send_word(rand_key(), i == n - 1);
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);
        // directed: extremes, signed zeros, ties, single element
        send_word(64'hffff_ffff_ffff_ffff, 0);
        send_word(64'h0, 0);
        send_word(64'h8000_0000_0000_0000, 0);
        send_word(64'h7ff0_0000_0000_0000, 0);
        send_word(64'hfff0_0000_0000_0000, 0);
        send_word(64'h3ff0_0000_0000_0000, 0);
        send_word(64'h3ff0_0000_0000_0000, 1);
        send_word(64'h4000_0000_0000_0000, 1);
        write_order(1);
        send_word(64'h3ff0_0000_0000_0000, 0);
        send_word(64'hbff0_0000_0000_0000, 0);
        send_word(64'h0, 0);
        send_word(64'h8000_0000_0000_0000, 0);
        send_word(64'h3ff0_0000_0000_0000, 1);
        // overflow: 66 keys with the long hold-off on the output, then more
        // keys offered while the row is still draining
        hold_cycles = 300;
        send_vector(66);
        send_vector(4);
        drain_all();
        write_order(0);
        send_idle = 8; recv_idle = 50;
        repeat (10) send_vector($urandom_range(1, 8));
        write_order(1);
        send_idle = 50; recv_idle = 8;
        repeat (10) send_vector($urandom_range(1, 8));
        write_order(0);
        send_idle = 0; recv_idle = 0;
        repeat (6) send_vector($urandom_range(1, 12));
        send_vector(64);
        // order change between keys of one vector
        send_word(rand_key(), 0);
        write_order(1);
        send_word(rand_key(), 1);
        drain_all();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

### stable_argsort_vector.f
src/sav_pkg.sv
src/sav_cell.sv
src/stable_argsort_vector.sv
dv/stable_argsort_vector_tb.sv
